@@ src/jlmp_pkg.sv @@
// joystick line parser package: byte codes, parse states, message kinds and widths
// used by joystick_line_to_motor_pwm_top; no dependencies
package jlmp_pkg;

	localparam int BYTE_W    = 8;
	localparam int VAL_W     = 16;
	localparam int ACC_W     = 17;
	localparam int THR_W     = 15;
	localparam int DUTY_W    = 10;
	localparam int KIND_W    = 2;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DAT_W = 15;
	localparam int PROD_W    = VAL_W + DUTY_W;

	localparam logic [BYTE_W-1:0] CH_NL    = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;
	localparam logic [BYTE_W-1:0] CH_G     = 8'h47;
	localparam logic [BYTE_W-1:0] CH_X     = 8'h58;
	localparam logic [BYTE_W-1:0] CH_Y     = 8'h59;
	localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
	localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
	localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
	localparam logic [BYTE_W-1:0] CH_VT    = 8'h0B;
	localparam logic [BYTE_W-1:0] CH_FF    = 8'h0C;
	localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;

	localparam logic [ACC_W-1:0] ACC_SAT = 17'd32768;
	localparam logic [VAL_W-1:0] VAL_MAX = 16'd32767;

	localparam logic [KIND_W-1:0] KIND_NONE = 2'd0;
	localparam logic [KIND_W-1:0] KIND_GX   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_GY   = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_DEADBAND   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE = 1'b1;

	localparam logic [THR_W-1:0]  DEADBAND_RST   = 15'd3277;
	localparam logic [DUTY_W-1:0] FULL_SCALE_RST = 10'd1023;

	typedef enum logic [3:0] {
		PH_NAME_START = 4'b0001,
		PH_NAME       = 4'b0010,
		PH_COLON      = 4'b0100,
		PH_VALUE      = 4'b1000
	} phase_t;

	typedef enum logic [4:0] {
		NP_NONE = 5'b00001,
		NP_G    = 5'b00010,
		NP_GX   = 5'b00100,
		NP_GY   = 5'b01000,
		NP_BAD  = 5'b10000
	} name_prog_t;

endpackage

@@ src/joystick_line_to_motor_pwm_top.sv @@
// a newline byte is held in the input register, then its result is written to the result
// register; other bytes give no result
// throughput: one byte per cycle, set by the combinational parse and duty path; a newline
// waits in the input register while the previous result is not yet accepted
// reset: parse state, held x/y/duty and valids clear; deadband 3277, full scale 1023
// joystick line parser and motor direction/pwm duty driver, depends on jlmp_pkg
module joystick_line_to_motor_pwm_top #(
	parameter int VALUE_FRACTION_BITS = 15
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [jlmp_pkg::BYTE_W-1:0]        rx_byte,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [jlmp_pkg::VAL_W-1:0]  joystick_x,
	output logic signed [jlmp_pkg::VAL_W-1:0]  joystick_y,
	output logic [jlmp_pkg::KIND_W-1:0]        message_kind,
	output logic                               drive_forward,
	output logic                               drive_reverse,
	output logic [jlmp_pkg::DUTY_W-1:0]        pwm_duty,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [jlmp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [jlmp_pkg::CFG_DAT_W-1:0]     cfg_data
);

	// config registers
	logic [jlmp_pkg::THR_W-1:0]  deadband_q;
	logic [jlmp_pkg::DUTY_W-1:0] full_scale_q;

	// input stage
	logic                        s1_valid_s1;
	logic [jlmp_pkg::BYTE_W-1:0] rx_s1;
	logic                        s1_go;
	logic                        is_nl;

	// parse state
	jlmp_pkg::phase_t            phase_q, phase_d;
	jlmp_pkg::name_prog_t        np_q, np_d;
	logic [jlmp_pkg::ACC_W-1:0]  acc_q, acc_d;
	logic                        neg_q, neg_d;
	logic                        fin_q, fin_d;
	logic                        started_q, started_d;
	logic                        value_en;
	logic                        is_digit, is_blank, is_sign;
	logic [19:0]                 acc_sum;

	// result
	logic signed [jlmp_pkg::VAL_W-1:0] held_x_q, held_y_q;
	logic [jlmp_pkg::DUTY_W-1:0]       held_duty_q;
	logic [jlmp_pkg::KIND_W-1:0]       kind_q, kind_d;
	logic                              fwd_q, rev_q;
	logic                              out_valid_q;

	logic signed [jlmp_pkg::VAL_W-1:0] val_d, y_new, x_new;
	logic signed [jlmp_pkg::ACC_W-1:0] y_ext, thr_ext;
	logic                              fwd_d, rev_d;
	logic [jlmp_pkg::VAL_W-1:0]        mag;
	logic [jlmp_pkg::PROD_W-1:0]       prod, scaled;
	logic [jlmp_pkg::DUTY_W-1:0]       duty_d;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deadband_q   <= jlmp_pkg::DEADBAND_RST;
			full_scale_q <= jlmp_pkg::FULL_SCALE_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				jlmp_pkg::REG_DEADBAND:   deadband_q   <= cfg_data[jlmp_pkg::THR_W-1:0];
				jlmp_pkg::REG_FULL_SCALE: full_scale_q <= cfg_data[jlmp_pkg::DUTY_W-1:0];
				default: ;
			endcase
		end
	end

	assign is_nl    = (rx_s1 == jlmp_pkg::CH_NL);
	assign s1_go    = s1_valid_s1 && (!is_nl || !out_valid_q || out_ready);
	assign in_ready = !s1_valid_s1 || s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (in_ready) begin
			s1_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			rx_s1 <= rx_byte;
		end
	end

	// byte classes for the value field
	assign is_digit = (rx_s1 >= jlmp_pkg::CH_ZERO) && (rx_s1 <= jlmp_pkg::CH_NINE);
	assign is_blank = (rx_s1 == jlmp_pkg::CH_SPACE) || (rx_s1 == jlmp_pkg::CH_TAB) ||
		(rx_s1 == jlmp_pkg::CH_VT) || (rx_s1 == jlmp_pkg::CH_FF) ||
		(rx_s1 == jlmp_pkg::CH_CR);
	assign is_sign  = (rx_s1 == jlmp_pkg::CH_PLUS) || (rx_s1 == jlmp_pkg::CH_MINUS);
	assign acc_sum  = {acc_q, 3'b000} + {2'b00, acc_q, 1'b0} +
		{12'd0, rx_s1 - jlmp_pkg::CH_ZERO};

	always_comb begin
		phase_d   = phase_q;
		np_d      = np_q;
		acc_d     = acc_q;
		neg_d     = neg_q;
		fin_d     = fin_q;
		started_d = started_q;
		value_en  = 1'b0;
		if (is_nl) begin
			phase_d   = jlmp_pkg::PH_NAME_START;
			np_d      = jlmp_pkg::NP_NONE;
			acc_d     = '0;
			neg_d     = 1'b0;
			fin_d     = 1'b0;
			started_d = 1'b0;
		end else begin
			case (phase_q)
				jlmp_pkg::PH_NAME_START: begin
					if (rx_s1 != jlmp_pkg::CH_COLON) begin
						phase_d = jlmp_pkg::PH_NAME;
						np_d    = (rx_s1 == jlmp_pkg::CH_G) ? jlmp_pkg::NP_G : jlmp_pkg::NP_BAD;
					end
				end
				jlmp_pkg::PH_NAME: begin
					if (rx_s1 == jlmp_pkg::CH_COLON) begin
						phase_d = jlmp_pkg::PH_COLON;
					end else if (np_q == jlmp_pkg::NP_G) begin
						np_d = (rx_s1 == jlmp_pkg::CH_X) ? jlmp_pkg::NP_GX :
							(rx_s1 == jlmp_pkg::CH_Y) ? jlmp_pkg::NP_GY : jlmp_pkg::NP_BAD;
					end else begin
						np_d = jlmp_pkg::NP_BAD;
					end
				end
				jlmp_pkg::PH_COLON: begin
					if (rx_s1 != jlmp_pkg::CH_COLON) begin
						phase_d  = jlmp_pkg::PH_VALUE;
						value_en = 1'b1;
					end
				end
				default: begin
					value_en = 1'b1;
				end
			endcase
			if (value_en && !fin_q) begin
				if (is_digit) begin
					started_d = 1'b1;
					acc_d     = (acc_sum > {3'b000, jlmp_pkg::ACC_SAT}) ?
						jlmp_pkg::ACC_SAT : acc_sum[jlmp_pkg::ACC_W-1:0];
				end else if (!started_q && is_blank) begin
					started_d = started_q;
				end else if (!started_q && is_sign) begin
					started_d = 1'b1;
					neg_d     = (rx_s1 == jlmp_pkg::CH_MINUS);
				end else begin
					fin_d = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= jlmp_pkg::PH_NAME_START;
			np_q      <= jlmp_pkg::NP_NONE;
			acc_q     <= '0;
			neg_q     <= 1'b0;
			fin_q     <= 1'b0;
			started_q <= 1'b0;
		end else if (s1_go) begin
			phase_q   <= phase_d;
			np_q      <= np_d;
			acc_q     <= acc_d;
			neg_q     <= neg_d;
			fin_q     <= fin_d;
			started_q <= started_d;
		end
	end

	// line end: kind, value, direction and duty
	always_comb begin
		kind_d = jlmp_pkg::KIND_NONE;
		if (phase_q == jlmp_pkg::PH_COLON || phase_q == jlmp_pkg::PH_VALUE) begin
			if (np_q == jlmp_pkg::NP_GX) begin
				kind_d = jlmp_pkg::KIND_GX;
			end else if (np_q == jlmp_pkg::NP_GY) begin
				kind_d = jlmp_pkg::KIND_GY;
			end
		end
		if (neg_q) begin
			val_d = -$signed(acc_q[jlmp_pkg::VAL_W-1:0]);
		end else if (acc_q > {1'b0, jlmp_pkg::VAL_MAX}) begin
			val_d = jlmp_pkg::VAL_MAX;
		end else begin
			val_d = acc_q[jlmp_pkg::VAL_W-1:0];
		end
		x_new   = (kind_d == jlmp_pkg::KIND_GX) ? val_d : held_x_q;
		y_new   = (kind_d == jlmp_pkg::KIND_GY) ? val_d : held_y_q;
		y_ext   = {y_new[jlmp_pkg::VAL_W-1], y_new};
		thr_ext = {2'b00, deadband_q};
		fwd_d   = (y_ext > thr_ext);
		rev_d   = (y_ext < -thr_ext);
		mag     = y_new[jlmp_pkg::VAL_W-1] ? 16'(-y_new) : 16'(y_new);
		prod    = {{jlmp_pkg::DUTY_W{1'b0}}, mag} * {{jlmp_pkg::VAL_W{1'b0}}, full_scale_q};
		scaled  = prod >> VALUE_FRACTION_BITS;
		if (!(fwd_d || rev_d)) begin
			duty_d = held_duty_q;
		end else if (scaled > {{jlmp_pkg::VAL_W{1'b0}}, full_scale_q}) begin
			duty_d = full_scale_q;
		end else begin
			duty_d = scaled[jlmp_pkg::DUTY_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_x_q    <= '0;
			held_y_q    <= '0;
			held_duty_q <= '0;
			kind_q      <= jlmp_pkg::KIND_NONE;
			fwd_q       <= 1'b0;
			rev_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (s1_go && is_nl) begin
			held_x_q    <= x_new;
			held_y_q    <= y_new;
			held_duty_q <= duty_d;
			kind_q      <= kind_d;
			fwd_q       <= fwd_d;
			rev_q       <= rev_d;
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid     = out_valid_q;
	assign joystick_x    = held_x_q;
	assign joystick_y    = held_y_q;
	assign message_kind  = kind_q;
	assign drive_forward = fwd_q;
	assign drive_reverse = rev_q;
	assign pwm_duty      = held_duty_q;

	a_dir_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(drive_forward && drive_reverse))
		else $error("forward and reverse both driven");

	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (message_kind == jlmp_pkg::KIND_NONE ||
			message_kind == jlmp_pkg::KIND_GX || message_kind == jlmp_pkg::KIND_GY))
		else $error("illegal message kind");

	a_duty_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (drive_forward || drive_reverse)) |-> (pwm_duty <= full_scale_q))
		else $error("duty above full scale");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (s1_valid_s1 && is_nl && out_valid_q && !out_ready))
		else $error("input stalled without a pending line result");

	a_parse_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_go && is_nl) |=> (phase_q == jlmp_pkg::PH_NAME_START && acc_q == '0))
		else $error("parse state not cleared after line end");

endmodule

@@ sim/joystick_line_checker.sv @@
// joystick line checker: tracks the byte, config and result channels of
// joystick_line_to_motor_pwm_top, predicts every motor update and compares it
// depends on jlmp_pkg
`timescale 1ns / 100ps

module joystick_line_checker #(
	parameter int VALUE_FRACTION_BITS = 15
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	input  logic                               in_ready,
	input  logic [jlmp_pkg::BYTE_W-1:0]        rx_byte,
	input  logic                               out_valid,
	input  logic                               out_ready,
	input  logic signed [jlmp_pkg::VAL_W-1:0]  joystick_x,
	input  logic signed [jlmp_pkg::VAL_W-1:0]  joystick_y,
	input  logic [jlmp_pkg::KIND_W-1:0]        message_kind,
	input  logic                               drive_forward,
	input  logic                               drive_reverse,
	input  logic [jlmp_pkg::DUTY_W-1:0]        pwm_duty,
	input  logic                               cfg_valid,
	input  logic                               cfg_ready,
	input  logic [jlmp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [jlmp_pkg::CFG_DAT_W-1:0]     cfg_data,
	output int                                 outstanding,
	output int                                 errors
);

	typedef struct packed {
		logic signed [jlmp_pkg::VAL_W-1:0] x;
		logic signed [jlmp_pkg::VAL_W-1:0] y;
		logic [jlmp_pkg::KIND_W-1:0]       kind;
		logic                              fwd;
		logic                              rev;
		logic [jlmp_pkg::DUTY_W-1:0]       duty;
	} motor_update_t;

	motor_update_t motor_update_q[$];

	jlmp_pkg::phase_t                  phase;
	jlmp_pkg::name_prog_t              name_prog;
	logic [jlmp_pkg::ACC_W-1:0]        magnitude;
	logic                              negative;
	logic                              number_done;
	logic                              number_seen;
	logic signed [jlmp_pkg::VAL_W-1:0] held_x;
	logic signed [jlmp_pkg::VAL_W-1:0] held_y;
	logic [jlmp_pkg::DUTY_W-1:0]       held_duty;
	logic [jlmp_pkg::THR_W-1:0]        deadband;
	logic [jlmp_pkg::DUTY_W-1:0]       full_scale;

	task automatic start_line;
		phase = jlmp_pkg::PH_NAME_START;
		name_prog = jlmp_pkg::NP_NONE;
		magnitude = '0;
		negative = 1'b0;
		number_done = 1'b0;
		number_seen = 1'b0;
	endtask

	task automatic take_value_char(input logic [jlmp_pkg::BYTE_W-1:0] c);
		int unsigned t;
		logic blank;
		blank = c == jlmp_pkg::CH_SPACE || c == jlmp_pkg::CH_TAB || c == jlmp_pkg::CH_VT ||
			c == jlmp_pkg::CH_FF || c == jlmp_pkg::CH_CR;
		if (!number_done) begin
			if (c >= jlmp_pkg::CH_ZERO && c <= jlmp_pkg::CH_NINE) begin
				number_seen = 1'b1;
				t = magnitude * 10 + (c - jlmp_pkg::CH_ZERO);
				if (t > 32768)
					t = 32768;
				magnitude = t[jlmp_pkg::ACC_W-1:0];
			end else if (!number_seen &&
				(c == jlmp_pkg::CH_PLUS || c == jlmp_pkg::CH_MINUS)) begin
				number_seen = 1'b1;
				negative = c == jlmp_pkg::CH_MINUS;
			end else if (number_seen || !blank) begin
				number_done = 1'b1;
			end
		end
	endtask

	task automatic compare_field(input string field, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : track
		motor_update_t e;
		logic [jlmp_pkg::KIND_W-1:0] kind;
		int v, y, thr;
		int unsigned mag, duty;
		if (!arst_n) begin
			start_line();
			held_x = '0;
			held_y = '0;
			held_duty = '0;
			deadband = jlmp_pkg::DEADBAND_RST;
			full_scale = jlmp_pkg::FULL_SCALE_RST;
			motor_update_q.delete();
			outstanding <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (motor_update_q.size() == 0) begin
					$display("%0t: result with none expected, got x=%0d y=%0d kind=%0d",
						$time, joystick_x, joystick_y, message_kind);
					errors++;
				end else begin
					e = motor_update_q.pop_front();
					compare_field("joystick_x", int'(e.x), int'(joystick_x));
					compare_field("joystick_y", int'(e.y), int'(joystick_y));
					compare_field("message_kind", int'(e.kind), int'(message_kind));
					compare_field("drive_forward", int'(e.fwd), int'(drive_forward));
					compare_field("drive_reverse", int'(e.rev), int'(drive_reverse));
					compare_field("pwm_duty", int'(e.duty), int'(pwm_duty));
				end
			end

			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
				jlmp_pkg::REG_DEADBAND: deadband = cfg_data[jlmp_pkg::THR_W-1:0];
				jlmp_pkg::REG_FULL_SCALE: full_scale = cfg_data[jlmp_pkg::DUTY_W-1:0];
				default: ;
				endcase
			end

			if (in_valid && in_ready) begin
				if (rx_byte != jlmp_pkg::CH_NL) begin
					case (phase)
					jlmp_pkg::PH_NAME_START: begin
						if (rx_byte != jlmp_pkg::CH_COLON) begin
							phase = jlmp_pkg::PH_NAME;
							name_prog = (rx_byte == jlmp_pkg::CH_G) ?
								jlmp_pkg::NP_G : jlmp_pkg::NP_BAD;
						end
					end
					jlmp_pkg::PH_NAME: begin
						if (rx_byte == jlmp_pkg::CH_COLON)
							phase = jlmp_pkg::PH_COLON;
						else if (name_prog == jlmp_pkg::NP_G)
							name_prog = (rx_byte == jlmp_pkg::CH_X) ? jlmp_pkg::NP_GX :
								(rx_byte == jlmp_pkg::CH_Y) ? jlmp_pkg::NP_GY :
								jlmp_pkg::NP_BAD;
						else
							name_prog = jlmp_pkg::NP_BAD;
					end
					jlmp_pkg::PH_COLON: begin
						if (rx_byte != jlmp_pkg::CH_COLON) begin
							phase = jlmp_pkg::PH_VALUE;
							take_value_char(rx_byte);
						end
					end
					default: take_value_char(rx_byte);
					endcase
				end else begin
					kind = jlmp_pkg::KIND_NONE;
					if (phase == jlmp_pkg::PH_COLON || phase == jlmp_pkg::PH_VALUE) begin
						if (name_prog == jlmp_pkg::NP_GX)
							kind = jlmp_pkg::KIND_GX;
						else if (name_prog == jlmp_pkg::NP_GY)
							kind = jlmp_pkg::KIND_GY;
					end
					if (negative)
						v = -int'(magnitude);
					else
						v = (magnitude > jlmp_pkg::VAL_MAX) ?
							int'(jlmp_pkg::VAL_MAX) : int'(magnitude);
					if (kind == jlmp_pkg::KIND_GX)
						held_x = v[jlmp_pkg::VAL_W-1:0];
					else if (kind == jlmp_pkg::KIND_GY)
						held_y = v[jlmp_pkg::VAL_W-1:0];

					y = held_y;
					thr = int'(deadband);
					e.fwd = 1'b0;
					e.rev = 1'b0;
					if (y < -thr || y > thr) begin
						e.rev = y < 0;
						e.fwd = y > 0;
						mag = (y < 0) ? -y : y;
						duty = (mag * full_scale) >> VALUE_FRACTION_BITS;
						if (duty > full_scale)
							duty = full_scale;
						held_duty = duty[jlmp_pkg::DUTY_W-1:0];
					end
					e.x = held_x;
					e.y = held_y;
					e.kind = kind;
					e.duty = held_duty;
					motor_update_q.push_back(e);
					start_line();
				end
			end
			outstanding <= motor_update_q.size();
		end
	end

endmodule

@@ sim/joystick_line_to_motor_pwm_top_test.sv @@
// testbench top for joystick_line_to_motor_pwm_top: directed and random command
// lines under several register settings, with random gaps on both channels
// depends on jlmp_pkg and joystick_line_checker
`timescale 1ns / 100ps

module joystick_line_to_motor_pwm_top_test;

	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASES = 6;
	localparam int PHASE_BYTES = 190;

	typedef logic [jlmp_pkg::BYTE_W-1:0] rx_byte_t;

	logic                                 clk;
	logic                                 arst_n;
	logic                                 in_valid;
	logic                                 in_ready;
	logic [jlmp_pkg::BYTE_W-1:0]          rx_byte;
	logic                                 out_valid;
	logic                                 out_ready;
	logic signed [jlmp_pkg::VAL_W-1:0]    joystick_x;
	logic signed [jlmp_pkg::VAL_W-1:0]    joystick_y;
	logic [jlmp_pkg::KIND_W-1:0]          message_kind;
	logic                                 drive_forward;
	logic                                 drive_reverse;
	logic [jlmp_pkg::DUTY_W-1:0]          pwm_duty;
	logic                                 cfg_valid;
	logic                                 cfg_ready;
	logic [jlmp_pkg::CFG_IDX_W-1:0]       cfg_index;
	logic [jlmp_pkg::CFG_DAT_W-1:0]       cfg_data;
	int                                   outstanding;
	int                                   errors;

	int   cycles = 0;
	int   stall_left = 0;
	int   bytes_sent = 0;
	logic line_gaps = 1'b1;
	logic ready_gaps = 1'b1;

	joystick_line_to_motor_pwm_top dut (.*);

	joystick_line_checker checker_i (.*);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	always @(posedge clk) begin
		if (stall_left != 0) begin
			out_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (ready_gaps && $urandom_range(0, 5) == 0) begin
			out_ready <= 1'b0;
			stall_left <= $urandom_range(0, 3);
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("joystick_line_to_motor_pwm_top_test: done, errors");
			$finish;
		end
	end

	task automatic send_byte(input logic [jlmp_pkg::BYTE_W-1:0] b);
		if (line_gaps && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (!in_ready);
		bytes_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	task automatic settle;
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_regs(input int deadband, input int full_scale);
		cfg_valid <= 1'b1;
		cfg_index <= jlmp_pkg::REG_DEADBAND;
		cfg_data <= deadband[jlmp_pkg::CFG_DAT_W-1:0];
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= jlmp_pkg::REG_FULL_SCALE;
		cfg_data <= full_scale[jlmp_pkg::CFG_DAT_W-1:0];
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		logic [jlmp_pkg::BYTE_W-1:0] line_q[$];
		int r, phase_end;
		arst_n = 1'b0;
		in_valid = 1'b0;
		rx_byte = '0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = jlmp_pkg::REG_DEADBAND;
		cfg_data = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset register values
		send_text("GY:40000\n");
		send_text("::GX:-99999\n");
		send_text("GY:-32768\n");
		send_text("GY\n");
		send_text("GX:\n");
		send_text("GY::\t -5000z7\n");
		send_text("GY:+12\n");
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(jlmp_pkg::CH_NL);
		send_text("GZ:5\n");
		settle();

		for (int p = 0; p < PHASES; p++) begin
			case (p)
			0: write_regs(0, 1023);
			1: write_regs(32767, 0);
			2: write_regs(1, 1);
			default: write_regs($urandom_range(0, 8000), $urandom_range(0, 1023));
			endcase
			phase_end = bytes_sent + PHASE_BYTES;
			while (bytes_sent < phase_end) begin
				line_gaps = (p != PHASES - 1) && $urandom_range(0, 3) != 0;
				ready_gaps <= line_gaps;
				r = $urandom_range(0, 9);
				if (r < 7) begin
					if ($urandom_range(0, 7) == 0)
						repeat ($urandom_range(1, 3)) line_q.push_back(jlmp_pkg::CH_COLON);
					line_q.push_back(jlmp_pkg::CH_G);
					line_q.push_back($urandom_range(0, 1) ? jlmp_pkg::CH_X : jlmp_pkg::CH_Y);
					repeat (($urandom_range(0, 5) == 0) ? 2 : 1)
						line_q.push_back(jlmp_pkg::CH_COLON);
					if ($urandom_range(0, 5) == 0) begin
						repeat ($urandom_range(1, 3)) begin
							case ($urandom_range(0, 4))
							0: line_q.push_back(jlmp_pkg::CH_SPACE);
							1: line_q.push_back(jlmp_pkg::CH_TAB);
							2: line_q.push_back(jlmp_pkg::CH_VT);
							3: line_q.push_back(jlmp_pkg::CH_FF);
							default: line_q.push_back(jlmp_pkg::CH_CR);
							endcase
						end
					end
					if ($urandom_range(0, 1))
						line_q.push_back(jlmp_pkg::CH_MINUS);
					else if ($urandom_range(0, 3) == 0)
						line_q.push_back(jlmp_pkg::CH_PLUS);
					repeat (($urandom_range(0, 9) == 0) ? $urandom_range(0, 8) :
						$urandom_range(3, 5))
						line_q.push_back(rx_byte_t'(jlmp_pkg::CH_ZERO + $urandom_range(0, 9)));
					if ($urandom_range(0, 5) == 0)
						repeat ($urandom_range(1, 4))
							line_q.push_back(rx_byte_t'($urandom_range(11, 255)));
				end else if (r == 7) begin
					// malformed names, sometimes with a value
					repeat ($urandom_range(1, 4)) begin
						case ($urandom_range(0, 3))
						0: line_q.push_back(jlmp_pkg::CH_G);
						1: line_q.push_back(jlmp_pkg::CH_X);
						2: line_q.push_back(jlmp_pkg::CH_Y);
						default: line_q.push_back(rx_byte_t'($urandom_range(0, 255)));
						endcase
					end
					if ($urandom_range(0, 1)) begin
						line_q.push_back(jlmp_pkg::CH_COLON);
						repeat ($urandom_range(0, 4))
							line_q.push_back(rx_byte_t'(jlmp_pkg::CH_ZERO + $urandom_range(0, 9)));
					end
				end else begin
					repeat ($urandom_range(1, 40))
						line_q.push_back(rx_byte_t'($urandom_range(0, 255)));
				end
				line_q.push_back(jlmp_pkg::CH_NL);
				foreach (line_q[i])
					send_byte(line_q[i]);
				line_q.delete();
			end
			settle();
		end

		if (errors == 0)
			$display("joystick_line_to_motor_pwm_top_test: done, clean");
		else
			$display("joystick_line_to_motor_pwm_top_test: done, errors");
		$finish;
	end

endmodule

@@ joystick_line_to_motor_pwm_top.f @@
src/jlmp_pkg.sv
src/joystick_line_to_motor_pwm_top.sv
sim/joystick_line_checker.sv
sim/joystick_line_to_motor_pwm_top_test.sv
